// ===== rtl/core/bcu_pkg.sv =====
package bcu_pkg;

    localparam logic [1:0] REG_TEMP_CALIB  = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
    localparam logic [1:0] REG_PRESS_NINE  = 2'd3;

    localparam logic [63:0] C_T_OFFSET   = 64'd128000;
    localparam logic [63:0] C_P_BASE     = 64'd1048576;
    localparam logic [63:0] C_P_SCALE    = 64'd3125;
    localparam logic [63:0] C_P_BIAS     = 64'd1 << 47;
    localparam logic [31:0] C_T_ROUND    = 32'd128;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_M1,
        S_T_M2,
        S_T_M3,
        S_T_FIN,
        S_P_SQ,
        S_P_V2A,
        S_P_V2B,
        S_P_A1,
        S_P_A2,
        S_P_A3,
        S_P_CHK,
        S_P_NUM,
        S_P_DIV,
        S_P_M9A,
        S_P_M9B,
        S_P_M8,
        S_P_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        run;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        kind;
        logic [31:0] temp;
        logic [31:0] press;
        logic        zero;
    } t_result;

    function automatic logic [63:0] sx16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

endpackage

// ===== rtl/core/bcu_if.sv =====
interface bcu_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [19:0] raw_sample;

    modport source (output valid, kind, raw_sample, input ready);
    modport sink   (input valid, kind, raw_sample, output ready);
endinterface

interface bcu_out_if;
    logic        valid;
    logic        ready;
    logic        kind_out;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        divisor_zero;

    modport source (output valid, kind_out, temperature_centi, pressure_q24_8, divisor_zero,
                    input ready);
    modport sink   (input valid, kind_out, temperature_centi, pressure_q24_8, divisor_zero,
                     output ready);
endinterface

// ===== rtl/core/bcu_mul.sv =====
module bcu_mul
    import bcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mul_req    i_req,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic [1:0]  r_ph;
    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_p;

    always_comb begin
        case (r_ph)
            2'd0: begin
                w_x = i_req.a[31:0];
                w_y = i_req.b[31:0];
            end
            2'd1: begin
                w_x = i_req.a[31:0];
                w_y = i_req.b[63:32];
            end
            default: begin
                w_x = i_req.a[63:32];
                w_y = i_req.b[31:0];
            end
        endcase
        w_p = w_x * w_y;
        case (r_ph)
            2'd0:    n_acc = w_p;
            2'd3:    n_acc = r_acc;
            default: n_acc = r_acc + {w_p[31:0], 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 2'd0;
        end else if (!i_req.run || r_ph == 2'd3) begin
            r_ph <= 2'd0;
        end else begin
            r_ph <= r_ph + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.run) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = i_req.run && r_ph == 2'd3;
    assign o_prod = r_acc;

endmodule

// ===== rtl/core/bcu_div.sv =====
module bcu_div
    import bcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_run,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    localparam logic [6:0] LAST = 7'd65;

    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic        r_neg;
    logic [64:0] w_sh;
    logic        w_ge;
    logic [64:0] w_sub;

    always_comb begin
        w_sh  = {r_rem, r_quo[63]};
        w_ge  = w_sh >= {1'b0, r_den};
        w_sub = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (!i_run || r_cnt == LAST) begin
            r_cnt <= 7'd0;
        end else begin
            r_cnt <= r_cnt + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run && r_cnt == 7'd0) begin
            r_rem <= 64'd0;
            r_quo <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_den <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_neg <= i_num[63] ^ i_den[63];
        end else if (i_run && r_cnt != LAST) begin
            r_rem <= w_ge ? w_sub[63:0] : w_sh[63:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_done = i_run && r_cnt == LAST;
    assign o_quo  = r_neg ? (64'd0 - r_quo) : r_quo;

endmodule

// ===== rtl/core/bcu_core.sv =====
module bcu_core
    import bcu_pkg::*;
#(
    parameter int RAW_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_kind,
    input  logic [19:0] i_raw,
    input  logic [47:0] i_tcal,
    input  logic [63:0] i_pcal_lo,
    input  logic [63:0] i_pcal_hi,
    input  logic [15:0] i_pcal_nine,
    input  logic        i_slot_free,
    output logic        o_idle,
    output logic        o_done,
    output t_result     o_res
);

    localparam int DROP = 20 - RAW_BITS;

    t_state      r_state;
    t_state      n_state;
    t_mul_req    w_mreq;
    logic        w_mdone;
    logic [63:0] w_prod;
    logic        w_drun;
    logic        w_ddone;
    logic [63:0] w_quo;

    logic        r_kind;
    logic [19:0] r_adc;
    logic [31:0] r_ft;
    logic [31:0] r_tv1;
    logic [31:0] r_tsq;
    logic [31:0] r_temp;
    logic [63:0] r_v1;
    logic [63:0] r_v2;
    logic [63:0] r_sq;
    logic [63:0] r_a;
    logic [63:0] r_num;
    logic [63:0] r_q;
    logic [31:0] r_press;
    logic        r_zero;

    logic [31:0] w_adc32;
    logic [31:0] w_ta;
    logic [31:0] w_td;
    logic [63:0] w_s13;
    logic [31:0] w_ft5;
    logic [63:0] w_sum;
    logic [63:0] w_p7;
    logic [63:0] w_fin;

    always_comb begin
        w_adc32 = {12'd0, r_adc};
        w_ta    = (w_adc32 >> 3) - {15'd0, i_tcal[15:0], 1'b0};
        w_td    = (w_adc32 >> 4) - {16'd0, i_tcal[15:0]};
        w_s13   = $signed(r_q) >>> 13;
        w_ft5   = {r_ft[29:0], 2'd0} + r_ft + C_T_ROUND;
        w_sum   = r_q + r_a + r_v2;
        w_p7    = sx16(i_pcal_hi[47:32]);
        w_fin   = ($signed(w_sum) >>> 8) + {w_p7[59:0], 4'd0};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = i_kind ? S_P_SQ : S_T_M1;
            S_T_M1:  if (w_mdone) n_state = S_T_M2;
            S_T_M2:  if (w_mdone) n_state = S_T_M3;
            S_T_M3:  if (w_mdone) n_state = S_T_FIN;
            S_T_FIN: n_state = S_DONE;
            S_P_SQ:  if (w_mdone) n_state = S_P_V2A;
            S_P_V2A: if (w_mdone) n_state = S_P_V2B;
            S_P_V2B: if (w_mdone) n_state = S_P_A1;
            S_P_A1:  if (w_mdone) n_state = S_P_A2;
            S_P_A2:  if (w_mdone) n_state = S_P_A3;
            S_P_A3:  if (w_mdone) n_state = S_P_CHK;
            S_P_CHK: n_state = (r_v1 == 64'd0) ? S_DONE : S_P_NUM;
            S_P_NUM: if (w_mdone) n_state = S_P_DIV;
            S_P_DIV: if (w_ddone) n_state = S_P_M9A;
            S_P_M9A: if (w_mdone) n_state = S_P_M9B;
            S_P_M9B: if (w_mdone) n_state = S_P_M8;
            S_P_M8:  if (w_mdone) n_state = S_P_FIN;
            S_P_FIN: n_state = S_DONE;
            S_DONE:  if (i_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_mreq = '0;
        w_drun = 1'b0;
        o_idle = 1'b0;
        o_done = 1'b0;
        case (r_state)
            S_IDLE:  o_idle = 1'b1;
            S_T_M1:  w_mreq = '{1'b1, {32'd0, w_ta}, sx16(i_tcal[31:16])};
            S_T_M2:  w_mreq = '{1'b1, {32'd0, w_td}, {32'd0, w_td}};
            S_T_M3:  w_mreq = '{1'b1, {32'd0, r_tsq}, sx16(i_tcal[47:32])};
            S_P_SQ:  w_mreq = '{1'b1, r_v1, r_v1};
            S_P_V2A: w_mreq = '{1'b1, r_sq, sx16(i_pcal_hi[31:16])};
            S_P_V2B: w_mreq = '{1'b1, r_v1, sx16(i_pcal_hi[15:0])};
            S_P_A1:  w_mreq = '{1'b1, r_sq, sx16(i_pcal_lo[47:32])};
            S_P_A2:  w_mreq = '{1'b1, r_v1, sx16(i_pcal_lo[31:16])};
            S_P_A3:  w_mreq = '{1'b1, r_a, {48'd0, i_pcal_lo[15:0]}};
            S_P_NUM: w_mreq = '{1'b1, r_num, C_P_SCALE};
            S_P_DIV: w_drun = 1'b1;
            S_P_M9A: w_mreq = '{1'b1, w_s13, sx16(i_pcal_nine)};
            S_P_M9B: w_mreq = '{1'b1, r_a, w_s13};
            S_P_M8:  w_mreq = '{1'b1, r_q, sx16(i_pcal_hi[63:48])};
            S_DONE:  o_done = i_slot_free;
            default: w_mreq = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ft    <= 32'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_T_M3 && w_mdone) begin
                r_ft <= r_tv1 + 32'($signed(w_prod[31:0]) >>> 14);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_start) begin
                r_kind <= i_kind;
                r_adc  <= (i_raw >> DROP) << DROP;
                r_zero <= 1'b0;
                r_v1   <= {{32{r_ft[31]}}, r_ft} - C_T_OFFSET;
            end
            S_T_M1:  if (w_mdone) r_tv1 <= 32'($signed(w_prod[31:0]) >>> 11);
            S_T_M2:  if (w_mdone) r_tsq <= 32'($signed(w_prod[31:0]) >>> 12);
            S_T_FIN: r_temp <= 32'($signed(w_ft5) >>> 8);
            S_P_SQ:  if (w_mdone) r_sq <= w_prod;
            S_P_V2A: if (w_mdone) r_v2 <= w_prod;
            S_P_V2B: if (w_mdone) begin
                r_v2 <= r_v2 + (w_prod << 17) + (sx16(i_pcal_lo[63:48]) << 35);
            end
            S_P_A1:  if (w_mdone) r_a <= $signed(w_prod) >>> 8;
            S_P_A2:  if (w_mdone) r_a <= r_a + (w_prod << 12) + C_P_BIAS;
            S_P_A3:  if (w_mdone) r_v1 <= $signed(w_prod) >>> 33;
            S_P_CHK: begin
                r_zero <= r_v1 == 64'd0;
                r_num  <= ((C_P_BASE - {44'd0, r_adc}) << 31) - r_v2;
            end
            S_P_NUM: if (w_mdone) r_num <= w_prod;
            S_P_DIV: if (w_ddone) r_q <= w_quo;
            S_P_M9A: if (w_mdone) r_a <= w_prod;
            S_P_M9B: if (w_mdone) r_a <= $signed(w_prod) >>> 25;
            S_P_M8:  if (w_mdone) r_v2 <= $signed(w_prod) >>> 19;
            S_P_FIN: r_press <= w_fin[31:0];
            default: r_press <= r_press;
        endcase
    end

    always_comb begin
        o_res.kind  = r_kind;
        o_res.temp  = r_kind ? 32'd0 : r_temp;
        o_res.press = (r_kind && !r_zero) ? r_press : 32'd0;
        o_res.zero  = r_kind && r_zero;
    end

    bcu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    bcu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (w_drun),
        .i_num   (r_num),
        .i_den   (r_v1),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

endmodule

// ===== rtl/core/barometric_compensation_unit.sv =====
// Barometric compensation unit.
// i_in carries raw readings (kind 0 temperature, 1 pressure); o_out carries
// one result beat per input beat, in order. Both use valid/ready; a beat
// moves when both are high.
// Calibration words go in through i_cfg_we/i_cfg_index/i_cfg_data; the user
// writes them only while the unit is idle; the block does not enforce it.
// Index 0 temp_calib, 1 press_calib_low, 2 press_calib_high,
// 3 press_calib_nine. One shared 64-bit multiplier (one 32x32 product per
// cycle) and one radix-2 divider do the arithmetic under a sequencer;
// i_in.ready is high only while the sequencer is idle.
// A new reading is taken only after the current result has left the
// sequencer. A pressure reading whose divisor is zero skips the division.
// A finished result sits in the output register; the next reading is taken
// while it waits. If the receiver stalls and a second result is ready, the
// sequencer holds it until the output register frees.
// Reset clears all calibration words, the stored fine temperature and the
// output valid.
module barometric_compensation_unit
    import bcu_pkg::*;
#(
    parameter int RAW_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcu_in_if.sink      i_in,
    bcu_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [47:0] r_tcal;
    logic [63:0] r_pcal_lo;
    logic [63:0] r_pcal_hi;
    logic [15:0] r_pcal_nine;
    logic        r_ovalid;
    t_result     r_ores;
    logic        w_idle;
    logic        w_done;
    logic        w_free;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal      <= 48'd0;
            r_pcal_lo   <= 64'd0;
            r_pcal_hi   <= 64'd0;
            r_pcal_nine <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEMP_CALIB: r_tcal      <= i_cfg_data[47:0];
                REG_PRESS_LOW:  r_pcal_lo   <= i_cfg_data;
                REG_PRESS_HIGH: r_pcal_hi   <= i_cfg_data;
                REG_PRESS_NINE: r_pcal_nine <= i_cfg_data[15:0];
                default:        r_tcal      <= r_tcal;
            endcase
        end
    end

    assign w_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_ores <= w_res;
        end
    end

    assign i_in.ready              = w_idle;
    assign o_out.valid             = r_ovalid;
    assign o_out.kind_out          = r_ores.kind;
    assign o_out.temperature_centi = r_ores.temp;
    assign o_out.pressure_q24_8    = r_ores.press;
    assign o_out.divisor_zero      = r_ores.zero;

    bcu_core #(
        .RAW_BITS (RAW_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid && w_idle),
        .i_kind      (i_in.kind),
        .i_raw       (i_in.raw_sample),
        .i_tcal      (r_tcal),
        .i_pcal_lo   (r_pcal_lo),
        .i_pcal_hi   (r_pcal_hi),
        .i_pcal_nine (r_pcal_nine),
        .i_slot_free (w_free),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_res       (w_res)
    );

endmodule

// ===== rtl/core/bcu_chk.sv =====
module bcu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind_out,
    input logic [31:0] i_temp,
    input logic [31:0] i_press,
    input logic        i_zero
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready high right after accept");

    a_temp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_kind_out |-> i_press == 32'd0 && !i_zero)
        else $error("temperature result carries pressure fields");

    a_press_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind_out |-> i_temp == 32'd0)
        else $error("pressure result carries temperature");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero |-> i_press == 32'd0)
        else $error("divisor zero with nonzero pressure");

endmodule

bind barometric_compensation_unit bcu_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind_out  (o_out.kind_out),
    .i_temp      (o_out.temperature_centi),
    .i_press     (o_out.pressure_q24_8),
    .i_zero      (o_out.divisor_zero)
);
